[rtl/core/stk_pkg.sv]
// package: shared constants and word types for the per-row top-k selector
`default_nettype none
package stk_pkg;
  localparam int MaxKeep    = 16;
  localparam int IdBits     = 32;
  localparam int WeightBits = 32;
  localparam int SlotBits   = (MaxKeep > 1) ? $clog2(MaxKeep) : 1;
  localparam int CountBits  = $clog2(MaxKeep + 1);
  localparam int KeepBits   = 5;
  localparam int QueueDepth = 2;

  localparam logic [0:0] RegKeepCount   = 1'b0;
  localparam logic [0:0] RegPickSmallest = 1'b1;

  typedef struct packed {
    logic [IdBits-1:0]            row_id;
    logic [IdBits-1:0]            col_id;
    logic [IdBits-1:0]            entry_id;
    logic signed [WeightBits-1:0] weight;
    logic                         end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic [IdBits-1:0]            out_row;
    logic [IdBits-1:0]            out_col;
    logic [IdBits-1:0]            out_entry;
    logic signed [WeightBits-1:0] out_weight;
    logic                         row_last;
  } out_word_t;

  // classified command passed from front to back
  typedef struct packed {
    logic                         flush_first;  // flush the open row before insert
    logic                         new_row;      // clear held set before insert
    logic                         flush_after;  // end of stream after insert
    logic [IdBits-1:0]            row_id;
    logic [IdBits-1:0]            col_id;
    logic [IdBits-1:0]            entry_id;
    logic signed [WeightBits-1:0] weight;
  } cmd_t;
endpackage
`default_nettype wire

[rtl/core/segmented_topk_selector.sv]
// top level: apb registers, front classifier, command queue, selection engine
// order: a row change flushes the old row (FLUSH1), then inserts (SCAN); an end
//   of stream word inserts (SCAN), then flushes (FLUSH2); others give no output
// one command at a time: an insert into a full row scans serially for the worst,
//   then shifts; a flush streams the held words and waits on output stalls
// reset (rst, synchronous): keep_count=16, pick_smallest=0, no row open
`default_nettype none
module segmented_topk_selector (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire stk_pkg::in_word_t   in_word,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output stk_pkg::out_word_t       out_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  logic [stk_pkg::KeepBits-1:0] keep_count;
  logic                         pick_smallest;
  stk_pkg::cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready;

  assign pready = 1'b1;

  // register writes at the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count    <= stk_pkg::KeepBits'(16);
      pick_smallest <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        stk_pkg::RegKeepCount:    keep_count    <= pwdata[stk_pkg::KeepBits-1:0];
        stk_pkg::RegPickSmallest: pick_smallest <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    unique case (paddr[2])
      stk_pkg::RegKeepCount:    prdata = 32'(keep_count);
      stk_pkg::RegPickSmallest: prdata = 32'(pick_smallest);
      default:                  prdata = '0;
    endcase
  end

  // classify rows at the front
  stk_front u_front (
    .clk, .rst, .in_word, .in_valid, .in_ready,
    .cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
  );

  // decouple so the front keeps taking words while the back flushes
  stk_queue u_queue (
    .clk, .rst, .wr_data(f_cmd), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(q_cmd), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  // selection and flush engine
  stk_back u_back (
    .clk, .rst, .cmd(q_cmd), .cmd_valid(q_valid), .cmd_ready(q_ready),
    .keep_count, .pick_smallest, .out_word, .out_valid, .out_ready
  );
endmodule
`default_nettype wire

[rtl/core/stk_front.sv]
// front end: tracks the open row and classifies each input word
`default_nettype none
module stk_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire stk_pkg::in_word_t in_word,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output stk_pkg::cmd_t        cmd,
  output logic                 cmd_valid,
  input  wire logic            cmd_ready
);
  logic [stk_pkg::IdBits-1:0] current_row;
  logic                       row_open;
  logic                       differ;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign differ    = in_word.row_id != current_row;

  always_comb begin
    cmd.flush_first = row_open && differ;
    cmd.new_row     = !row_open || differ;
    cmd.flush_after = in_word.end_of_stream;
    cmd.row_id      = in_word.row_id;
    cmd.col_id      = in_word.col_id;
    cmd.entry_id    = in_word.entry_id;
    cmd.weight      = in_word.weight;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_row <= '0;
      row_open    <= 1'b0;
    end else if (in_valid && in_ready) begin
      current_row <= in_word.row_id;
      row_open    <= !in_word.end_of_stream;
    end
  end
endmodule
`default_nettype wire

[rtl/core/stk_queue.sv]
// short fifo between front and back
`default_nettype none
module stk_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire stk_pkg::cmd_t wr_data,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  output stk_pkg::cmd_t      rd_data,
  output logic               rd_valid,
  input  wire logic          rd_ready
);
  stk_pkg::cmd_t mem [stk_pkg::QueueDepth];
  logic       wp, rp;
  logic [1:0] fill;
  logic       wr_en, rd_en;

  assign wr_ready = fill != 2'(stk_pkg::QueueDepth);
  assign rd_valid = fill != 2'd0;
  assign rd_data  = mem[rp];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr_en) wp <= ~wp;
      if (rd_en) rp <= ~rp;
      fill <= fill + 2'(wr_en) - 2'(rd_en);
    end
  end
endmodule
`default_nettype wire

[rtl/core/stk_back.sv]
// back end: holds the row's kept entries, replaces the worst, streams flushes
`default_nettype none
module stk_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire stk_pkg::cmd_t                 cmd,
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  input  wire logic [stk_pkg::KeepBits-1:0]  keep_count,
  input  wire logic                          pick_smallest,
  output stk_pkg::out_word_t                 out_word,
  output logic                               out_valid,
  input  wire logic                          out_ready
);
  localparam int N  = stk_pkg::MaxKeep;
  localparam int SB = stk_pkg::SlotBits;
  localparam int CB = stk_pkg::CountBits;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_FLUSH1 = 5'b00010,
    S_SCAN   = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_FLUSH2 = 5'b10000
  } state_t;

  state_t state;
  logic [stk_pkg::IdBits-1:0]     held_col    [N];
  logic [stk_pkg::IdBits-1:0]     held_entry  [N];
  logic [stk_pkg::WeightBits-1:0] held_weight [N];
  logic [CB-1:0] held_count;
  logic [stk_pkg::IdBits-1:0] flush_row_id;
  logic [stk_pkg::IdBits-1:0] p_row_hold;
  logic [CB-1:0] idx;     // flush, scan or shift pointer
  logic [SB-1:0] worst;
  logic [CB-1:0] k;
  logic [SB-1:0] idx_s;
  logic [SB-1:0] last_s;

  assign k = (keep_count > stk_pkg::KeepBits'(N)) ? CB'(N) : CB'(keep_count);
  assign idx_s  = idx[SB-1:0];
  assign last_s = SB'(held_count - CB'(1));

  function automatic logic better(input logic [stk_pkg::WeightBits-1:0] a,
                                  input logic [stk_pkg::WeightBits-1:0] b,
                                  input logic sm);
    logic signed [stk_pkg::WeightBits-1:0] sa, sb;
    sa = a;
    sb = b;
    return sm ? (sa < sb) : (sa > sb);
  endfunction

  // output register
  logic out_free;
  logic load_out;
  assign out_free  = !out_valid || out_ready;
  assign load_out  = out_free && (state == S_FLUSH1 || state == S_FLUSH2) &&
                     (idx < held_count);
  assign cmd_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word.out_row    <= flush_row_id;
      out_word.out_col    <= held_col[idx_s];
      out_word.out_entry  <= held_entry[idx_s];
      out_word.out_weight <= held_weight[idx_s];
      out_word.row_last   <= (idx + CB'(1)) == held_count;
    end
  end

  logic [stk_pkg::IdBits-1:0]     p_col, p_ent;
  logic [stk_pkg::WeightBits-1:0] p_w;
  logic                           p_eos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_count <= '0;
      idx        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            p_col <= cmd.col_id;
            p_ent <= cmd.entry_id;
            p_w   <= cmd.weight;
            p_eos <= cmd.flush_after;
            if (cmd.flush_first) begin
              p_row_hold <= cmd.row_id;
              idx        <= '0;
              state      <= S_FLUSH1;
            end else begin
              if (cmd.new_row) held_count <= '0;
              flush_row_id <= cmd.row_id;
              state <= S_SCAN;
              idx   <= CB'(1);
              worst <= '0;
            end
          end
        end
        S_FLUSH1, S_FLUSH2: begin
          if (idx >= held_count) begin
            held_count <= '0;
            if (state == S_FLUSH1) begin
              flush_row_id <= p_row_hold;
              idx   <= CB'(1);
              worst <= '0;
              state <= S_SCAN;
            end else begin
              idx   <= '0;
              state <= S_IDLE;
            end
          end else if (out_free) begin
            idx <= idx + CB'(1);
          end
        end
        S_SCAN: begin
          if (held_count < k) begin
            held_col[SB'(held_count)]    <= p_col;
            held_entry[SB'(held_count)]  <= p_ent;
            held_weight[SB'(held_count)] <= p_w;
            held_count <= held_count + CB'(1);
            idx   <= '0;
            state <= p_eos ? S_FLUSH2 : S_IDLE;
          end else if (k == '0 || held_count == '0) begin
            idx   <= '0;
            state <= p_eos ? S_FLUSH2 : S_IDLE;
          end else if (idx < held_count) begin
            if (!better(held_weight[idx_s], held_weight[worst], pick_smallest))
              worst <= idx_s;
            idx <= idx + CB'(1);
          end else if (better(p_w, held_weight[worst], pick_smallest)) begin
            idx   <= CB'(worst);
            state <= S_SHIFT;
          end else begin
            idx   <= '0;
            state <= p_eos ? S_FLUSH2 : S_IDLE;
          end
        end
        S_SHIFT: begin
          if (idx_s == last_s) begin
            held_col[last_s]    <= p_col;
            held_entry[last_s]  <= p_ent;
            held_weight[last_s] <= p_w;
            idx   <= '0;
            state <= p_eos ? S_FLUSH2 : S_IDLE;
          end else begin
            held_col[idx_s]    <= held_col[SB'(idx + CB'(1))];
            held_entry[idx_s]  <= held_entry[SB'(idx + CB'(1))];
            held_weight[idx_s] <= held_weight[SB'(idx + CB'(1))];
            idx <= idx + CB'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[tb/sv/segmented_topk_selector_checker.sv]
// checker: per-row top-k predictor and result scoreboard for the selector
module segmented_topk_selector_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire stk_pkg::in_word_t  in_word,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire stk_pkg::out_word_t out_word,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  input  wire logic               pready,
  output int                      fail_count,
  output int                      pending_count,
  output int                      result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [4:0] keep_sel;
  logic       smallest_mode;
  logic [31:0] open_row;
  logic       row_active;
  int         held_n;
  logic [31:0] slot_col [stk_pkg::MaxKeep];
  logic [31:0] slot_ent [stk_pkg::MaxKeep];
  logic signed [31:0] slot_w [stk_pkg::MaxKeep];
  stk_pkg::out_word_t selected_q[$];

  function automatic bit ranks_above(logic signed [31:0] a, logic signed [31:0] b);
    return smallest_mode ? (a < b) : (a > b);
  endfunction

  task automatic flush_held();
    stk_pkg::out_word_t w;
    for (int i = 0; i < held_n; i++) begin
      w.out_row = open_row;
      w.out_col = slot_col[i];
      w.out_entry = slot_ent[i];
      w.out_weight = slot_w[i];
      w.row_last = (i == held_n - 1);
      selected_q.insert(selected_q.size(), w);
    end
    held_n = 0;
  endtask

  task automatic admit_entry(stk_pkg::in_word_t e);
    int k;
    int worst;
    k = (keep_sel > stk_pkg::MaxKeep) ? stk_pkg::MaxKeep : int'(keep_sel);
    if (held_n < k) begin
      slot_col[held_n] = e.col_id;
      slot_ent[held_n] = e.entry_id;
      slot_w[held_n] = e.weight;
      held_n++;
      return;
    end
    if (k == 0 || held_n == 0) return;
    worst = 0;
    for (int i = 1; i < held_n; i++)
      if (!ranks_above(slot_w[i], slot_w[worst])) worst = i;
    if (!ranks_above(e.weight, slot_w[worst])) return;
    for (int i = worst; i + 1 < held_n; i++) begin
      slot_col[i] = slot_col[i+1];
      slot_ent[i] = slot_ent[i+1];
      slot_w[i] = slot_w[i+1];
    end
    slot_col[held_n-1] = e.col_id;
    slot_ent[held_n-1] = e.entry_id;
    slot_w[held_n-1] = e.weight;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    stk_pkg::out_word_t want;
    if (rst) begin
      keep_sel <= 5'd16;
      smallest_mode <= 1'b0;
      row_active = 1'b0;
      open_row = '0;
      held_n = 0;
      selected_q.delete();
      fail_count = 0;
      result_count <= 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == stk_pkg::RegKeepCount) keep_sel <= pwdata[4:0];
        else smallest_mode <= pwdata[0];
      end
      // result side first: older expectations were queued by earlier items
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (selected_q.size() == 0) begin
          report_mismatch("unexpected word, row", out_word.out_row, 32'h0);
        end else begin
          want = selected_q.pop_front();
          if (out_word.out_row !== want.out_row)
            report_mismatch("out_row", out_word.out_row, want.out_row);
          if (out_word.out_col !== want.out_col)
            report_mismatch("out_col", out_word.out_col, want.out_col);
          if (out_word.out_entry !== want.out_entry)
            report_mismatch("out_entry", out_word.out_entry, want.out_entry);
          if (out_word.out_weight !== want.out_weight)
            report_mismatch("out_weight", out_word.out_weight, want.out_weight);
          if (out_word.row_last !== want.row_last)
            report_mismatch("row_last", {31'b0, out_word.row_last}, {31'b0, want.row_last});
        end
      end
      if (in_valid && in_ready) begin
        if (row_active && in_word.row_id != open_row) flush_held();
        if (!row_active || in_word.row_id != open_row) begin
          open_row = in_word.row_id;
          row_active = 1'b1;
          held_n = 0;
        end
        admit_entry(in_word);
        if (in_word.end_of_stream) begin
          flush_held();
          row_active = 1'b0;
        end
      end
    end
    pending_count = selected_q.size();
  end
endmodule

[tb/sv/segmented_topk_selector_tb.sv]
// testbench top: stimulus, register phases and verdict for the top-k selector
module segmented_topk_selector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  stk_pkg::in_word_t in_word = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  stk_pkg::out_word_t out_word;
  logic out_valid;
  logic out_ready = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int fail_count;
  int pending_count;
  int result_count;
  int words_sent = 0;
  int idle_cycles = 0;
  // idling odds in percent for each side
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  bit recv_hold = 1'b0;
  logic [31:0] row_cursor = 32'd100;

  always #4 clk = ~clk;

  segmented_topk_selector dut (
    .clk, .rst, .in_word, .in_valid, .in_ready, .out_word, .out_valid,
    .out_ready, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  segmented_topk_selector_checker chk (
    .clk, .rst, .in_word, .in_valid, .in_ready, .out_word, .out_valid,
    .out_ready, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending_count, .result_count
  );

  // receiver: random stalls unless a long hold-off is in force
  always @(negedge clk) begin
    if (recv_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_gap_pct);
  end

  // watchdog: cycles with no word moving on either channel and no apb access
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("watchdog expired, %0d words pending", pending_count);
      $display("segmented_topk_selector_tb NOT OK");
      $finish;
    end
  end

  // apb write; callers use it only while the block is idle, it does not check
  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // offer one word, holding it until taken; optional gap first
  task automatic send_word(stk_pkg::in_word_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_word = w;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_entry(logic [31:0] row, logic [31:0] col, logic [31:0] ent,
                            logic [31:0] w, logic eos);
    stk_pkg::in_word_t x;
    x.row_id = row; x.col_id = col; x.entry_id = ent;
    x.weight = w; x.end_of_stream = eos;
    send_word(x);
  endtask

  // wait for every expected word, then let queued full-row inserts finish
  task automatic drain();
    while (pending_count != 0) @(negedge clk);
    repeat ((stk_pkg::QueueDepth + 2) * (2 * stk_pkg::MaxKeep + 4)) @(negedge clk);
  endtask

  // a sorted run of rows with random content; weights often collide for ties
  task automatic random_rows(int n_items);
    int left;
    int len;
    logic [31:0] w;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 6);
      if (len > left) len = left;
      row_cursor += $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(3))
          0: w = $urandom_range(7);
          1: w = $urandom;
          2: w = {1'($urandom_range(1)), 31'h7fff_fff0 + 31'($urandom_range(15))};
          default: w = -$urandom_range(20);
        endcase
        send_entry(row_cursor, $urandom, $urandom, w,
                   (i == len - 1) && ($urandom_range(5) == 0));
      end
      left -= len;
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes of each field, ties, full-buffer replacement, eos
    send_entry(32'h0, 32'h0, 32'h0, 32'h8000_0000, 1'b0);
    send_entry(32'h0, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 1'b0);
    send_entry(32'h0, 32'h5555_5555, 32'haaaa_aaaa, 32'h0, 1'b1);
    send_entry(32'hffff_ffff, 32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff, 1'b1);
    drain();
    write_reg(stk_pkg::RegKeepCount, 32'd2);
    // ties: equal weights, earliest kept; better one replaces the latest tie
    send_entry(32'd5, 32'd1, 32'd1, 32'd7, 1'b0);
    send_entry(32'd5, 32'd2, 32'd2, 32'd7, 1'b0);
    send_entry(32'd5, 32'd3, 32'd3, 32'd7, 1'b0);
    send_entry(32'd5, 32'd4, 32'd4, 32'd9, 1'b0);
    // row change flushes the old row
    send_entry(32'd6, 32'd5, 32'd5, -32'sd3, 1'b1);
    drain();
    write_reg(stk_pkg::RegPickSmallest, 32'd1);
    send_entry(32'd7, 32'd1, 32'd1, 32'd4, 1'b0);
    send_entry(32'd7, 32'd2, 32'd2, -32'sd4, 1'b0);
    send_entry(32'd7, 32'd3, 32'd3, 32'd0, 1'b0);
    // change k inside a row: held entries stay beyond the new k
    drain();
    write_reg(stk_pkg::RegKeepCount, 32'd1);
    send_entry(32'd7, 32'd4, 32'd4, -32'sd9, 1'b1);
    drain();
    // zero keep: nothing comes out
    write_reg(stk_pkg::RegKeepCount, 32'd0);
    send_entry(32'd8, 32'd1, 32'd1, 32'd1, 1'b0);
    send_entry(32'd9, 32'd1, 32'd1, 32'd1, 1'b1);
    drain();
    // oversized keep acts as the buffer depth; full row of 17 then eos
    write_reg(stk_pkg::RegKeepCount, 32'd31);
    write_reg(stk_pkg::RegPickSmallest, 32'd0);
    for (int i = 0; i < 17; i++)
      send_entry(32'd10, i, i, i % 5, 1'b0);
    send_entry(32'd11, 32'd0, 32'd0, 32'd1, 1'b1);
    drain();

    // random phases across settings and idling patterns
    write_reg(stk_pkg::RegKeepCount, 32'd16);
    send_gap_pct = 21; recv_gap_pct = 51;
    random_rows(25);
    send_entry(row_cursor, 32'd0, 32'd0, 32'd0, 1'b1);
    drain();
    write_reg(stk_pkg::RegKeepCount, 32'd3);
    write_reg(stk_pkg::RegPickSmallest, 32'd1);
    send_gap_pct = 51; recv_gap_pct = 21;
    random_rows(25);
    drain();

    // receiver holds off while the sender keeps pushing, so the block backs up
    write_reg(stk_pkg::RegKeepCount, 32'd1);
    write_reg(stk_pkg::RegPickSmallest, 32'd0);
    send_gap_pct = 0; recv_gap_pct = 0;
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(negedge clk);
        recv_hold = 1'b0;
      end
      random_rows(25);
    join
    send_entry(row_cursor, 32'd1, 32'd1, 32'd1, 1'b1);
    drain();

    $display("covered %0d input words and %0d result words over keep 0..31,",
             words_sent, result_count);
    $display("both ranking modes, ties, row changes, stalls and a long output hold-off");
    if (fail_count == 0) begin
      $display("segmented_topk_selector_tb OK");
    end else begin
      $display("segmented_topk_selector_tb NOT OK");
    end
    $finish;
  end
endmodule

[files.f]
rtl/core/stk_pkg.sv
rtl/core/stk_front.sv
rtl/core/stk_queue.sv
rtl/core/stk_back.sv
rtl/core/segmented_topk_selector.sv
tb/sv/segmented_topk_selector_checker.sv
tb/sv/segmented_topk_selector_tb.sv
